// ----- sv/smx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and the base-2 table for the softmax vector unit.
// ----------------------------------------------------------------------------
package smx_pkg;

   // default vector capacity
   localparam int MAX_ELEMENTS_DEF = 16;
   // count field of a queued job covers the whole capacity range (up to 127)
   localparam int JOB_CNT_W = 7;
   // exponential and probability width, Q0.16 / Q1.16
   localparam int EXP_W = 17;
   // division: numerator e*65536 + sum/2 and number of quotient bits
   localparam int NUM_W = 34;
   localparam int QUO_W = 17;
   // exp cutoff, -16 in Q8.8, and log2(e) in Q8.8
   localparam logic [15:0] EXP_CUTOFF = 16'd4096;
   localparam logic [8:0] LOG2E_Q8 = 9'd369;

   // input item
   typedef struct packed {
      logic signed [15:0] logit;
      logic               last_logit;
   } req_type;

   // result item
   typedef struct packed {
      logic [3:0]       elem_index;
      logic [EXP_W-1:0] probability;
      logic             last_probability;
      logic             overflow;
   } rsp_type;

   // one finished vector handed from front to back
   typedef struct packed {
      logic [JOB_CNT_W-1:0] count;
      logic signed [15:0]   max_score;
      logic                 dropped;
   } job_type;

   // job queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
      logic wr_bank;
      logic rd_bank;
   } queue_status_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXP_READ,
      BK_EXP_SCALE,
      BK_EXP_INTERP,
      BK_DIV_READ,
      BK_DIV_LOAD,
      BK_DIV_RUN,
      BK_DIV_OUT
   } back_state_type;

   // round(2^(-i/16) * 65536)
   function automatic logic [EXP_W-1:0] pow2_entry(input logic [4:0] idx);
      logic [EXP_W-1:0] val;
      case (idx)
         5'd0:    val = 17'd65536;
         5'd1:    val = 17'd62757;
         5'd2:    val = 17'd60097;
         5'd3:    val = 17'd57549;
         5'd4:    val = 17'd55109;
         5'd5:    val = 17'd52773;
         5'd6:    val = 17'd50535;
         5'd7:    val = 17'd48393;
         5'd8:    val = 17'd46341;
         5'd9:    val = 17'd44376;
         5'd10:   val = 17'd42495;
         5'd11:   val = 17'd40693;
         5'd12:   val = 17'd38968;
         5'd13:   val = 17'd37316;
         5'd14:   val = 17'd35734;
         5'd15:   val = 17'd34219;
         5'd16:   val = 17'd32768;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- sv/smx_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/smx_job_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smx_job_queue
// Two-entry job queue; its pointers also select the score buffer bank.
// ----------------------------------------------------------------------------
module smx_job_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire smx_pkg::job_type          push_job,
   input  wire logic                      pop,
   output smx_pkg::job_type               head_job,
   output smx_pkg::queue_status_type      status
);

   smx_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job       = entry_ff[rd_ptr_ff];
   assign status.full    = fill_ff[1];
   assign status.empty   = (fill_ff == 2'd0);
   assign status.wr_bank = wr_ptr_ff;
   assign status.rd_bank = rd_ptr_ff;

endmodule
`default_nettype wire

// ----- sv/smx_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smx_front
// Accepts scores, stores them, tracks count, maximum and drops per vector.
// ----------------------------------------------------------------------------
module smx_front #(
   parameter int MAX_ELEMENTS = smx_pkg::MAX_ELEMENTS_DEF,
   localparam int IDX_W = $clog2(MAX_ELEMENTS),
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire smx_pkg::req_type          req_item,
   output logic                           req_stall,
   input  wire smx_pkg::queue_status_type qstatus,
   output logic                           score_we,
   output logic [IDX_W:0]                 score_waddr,
   output logic [15:0]                    score_wdata,
   output logic                           push,
   output smx_pkg::job_type               push_job
);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [15:0] max_ff, max_in;
   logic               dropped_ff, dropped_in;
   logic               accept;
   logic               has_room;
   logic [CNT_W-1:0]   count_next;
   logic signed [15:0] max_next;
   logic               dropped_next;

   // stall while both score banks hold pending vectors
   assign req_stall = qstatus.full;
   assign accept    = req_valid && !req_stall;
   assign has_room  = (count_ff < CNT_W'(MAX_ELEMENTS));

   // vector state after this item
   always_comb begin
      count_next   = count_ff;
      max_next     = max_ff;
      dropped_next = dropped_ff;
      if (has_room) begin
         count_next = count_ff + CNT_W'(1);
         if (req_item.logit > max_ff) begin
            max_next = req_item.logit;
         end
      end else begin
         dropped_next = 1'b1;
      end
   end

   // clear on the last item, hold when idle
   always_comb begin
      count_in   = count_ff;
      max_in     = max_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         if (req_item.last_logit) begin
            count_in   = '0;
            max_in     = 16'sh8000;
            dropped_in = 1'b0;
         end else begin
            count_in   = count_next;
            max_in     = max_next;
            dropped_in = dropped_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         max_ff     <= 16'sh8000;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         max_ff     <= max_in;
         dropped_ff <= dropped_in;
      end
   end

   // score write into the bank owned by the front
   assign score_we    = accept && has_room;
   assign score_waddr = {qstatus.wr_bank, count_ff[IDX_W-1:0]};
   assign score_wdata = req_item.logit;

   // hand the finished vector to the back
   assign push               = accept && req_item.last_logit;
   assign push_job.count     = smx_pkg::JOB_CNT_W'(count_next);
   assign push_job.max_score = max_next;
   assign push_job.dropped   = dropped_next;

endmodule
`default_nettype wire

// ----- sv/smx_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smx_back
// Per vector: exponentials and their sum, then one serial division per item.
// ----------------------------------------------------------------------------
module smx_back #(
   parameter int MAX_ELEMENTS = smx_pkg::MAX_ELEMENTS_DEF,
   localparam int IDX_W = $clog2(MAX_ELEMENTS),
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
   localparam int SUM_W = smx_pkg::EXP_W + $clog2(MAX_ELEMENTS)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire smx_pkg::job_type          job,
   input  wire smx_pkg::queue_status_type qstatus,
   output logic                           pop,
   output logic [IDX_W:0]                 score_raddr,
   input  wire logic [15:0]               score_rdata,
   output logic                           exp_we,
   output logic [IDX_W-1:0]               exp_addr,
   output logic [smx_pkg::EXP_W-1:0]      exp_wdata,
   input  wire logic [smx_pkg::EXP_W-1:0] exp_rdata,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output smx_pkg::rsp_type               rsp_item
);

   localparam int EW = smx_pkg::EXP_W;
   localparam int QW = smx_pkg::QUO_W;
   localparam int NW = smx_pkg::NUM_W;

   smx_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [13:0]      t_ff, t_in;
   logic             zero_ff, zero_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [4:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   smx_pkg::rsp_type rsp_ff, rsp_in;

   logic             is_last;
   logic             out_free;
   logic signed [16:0] diff;
   logic [21:0]      scaled;
   logic [5:0]       shift_k;
   logic [4:0]       tab_j;
   logic [EW-1:0]    tab_a, tab_b, tab_gap, mant, exp_val;
   logic [20:0]      interp;
   logic [NW-1:0]    numer;
   logic [SUM_W:0]   trial;
   logic [CNT_W+3:0] idx_wide;

   assign is_last  = (smx_pkg::JOB_CNT_W'(idx_ff) + smx_pkg::JOB_CNT_W'(1)) == job.count;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // exp stage 1: distance below max, scaled to base 2 (Q8.8)
   always_comb begin
      diff   = 17'(job.max_score) - 17'(signed'(score_rdata));
      scaled = 22'(diff[12:0]) * 22'(smx_pkg::LOG2E_Q8) + 22'd128;
   end

   // exp stage 2: table interpolation and right shift
   always_comb begin
      shift_k = t_ff[13:8];
      tab_j   = {1'b0, t_ff[7:4]};
      tab_a   = smx_pkg::pow2_entry(tab_j);
      tab_b   = smx_pkg::pow2_entry(tab_j + 5'd1);
      tab_gap = tab_a - tab_b;
      interp  = 21'(tab_gap) * 21'(t_ff[3:0]) + 21'd8;
      mant    = tab_a - EW'(interp[20:4]);
      if (zero_ff || shift_k >= 6'd17) begin
         exp_val = '0;
      end else begin
         exp_val = mant >> shift_k;
      end
   end

   // divider: numerator and one restoring step
   always_comb begin
      numer = {1'b0, exp_rdata, 16'd0} + NW'(sum_ff >> 1);
      trial = {rem_ff, quo_ff[QW-1]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smx_pkg::BK_IDLE: begin
            if (!qstatus.empty) begin
               state_in = smx_pkg::BK_EXP_READ;
            end
         end
         smx_pkg::BK_EXP_READ:  state_in = smx_pkg::BK_EXP_SCALE;
         smx_pkg::BK_EXP_SCALE: state_in = smx_pkg::BK_EXP_INTERP;
         smx_pkg::BK_EXP_INTERP: begin
            state_in = is_last ? smx_pkg::BK_DIV_READ : smx_pkg::BK_EXP_READ;
         end
         smx_pkg::BK_DIV_READ: state_in = smx_pkg::BK_DIV_LOAD;
         smx_pkg::BK_DIV_LOAD: state_in = smx_pkg::BK_DIV_RUN;
         smx_pkg::BK_DIV_RUN: begin
            if (step_ff == 5'd1) begin
               state_in = smx_pkg::BK_DIV_OUT;
            end
         end
         smx_pkg::BK_DIV_OUT: begin
            if (out_free) begin
               state_in = is_last ? smx_pkg::BK_IDLE : smx_pkg::BK_DIV_READ;
            end
         end
         default: state_in = smx_pkg::BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      exp_we = (state_ff == smx_pkg::BK_EXP_INTERP);
      pop    = (state_ff == smx_pkg::BK_DIV_OUT) && out_free && is_last;
   end

   assign score_raddr = {qstatus.rd_bank, idx_ff[IDX_W-1:0]};
   assign exp_addr    = idx_ff[IDX_W-1:0];
   assign exp_wdata   = exp_val;
   assign idx_wide    = {4'd0, idx_ff};

   // datapath registers
   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      t_in         = t_ff;
      zero_in      = zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         smx_pkg::BK_IDLE: begin
            idx_in = '0;
            sum_in = '0;
         end
         smx_pkg::BK_EXP_SCALE: begin
            t_in    = scaled[21:8];
            zero_in = (diff[15:0] > smx_pkg::EXP_CUTOFF);
         end
         smx_pkg::BK_EXP_INTERP: begin
            sum_in = sum_ff + SUM_W'(exp_val);
            idx_in = is_last ? '0 : idx_ff + CNT_W'(1);
         end
         smx_pkg::BK_DIV_LOAD: begin
            rem_in  = SUM_W'(numer[NW-1:QW]);
            quo_in  = numer[QW-1:0];
            step_in = 5'(QW);
         end
         smx_pkg::BK_DIV_RUN: begin
            step_in = step_ff - 5'd1;
            if (trial >= {1'b0, sum_ff}) begin
               rem_in = SUM_W'(trial - {1'b0, sum_ff});
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial[SUM_W-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
         end
         smx_pkg::BK_DIV_OUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.elem_index        = idx_wide[3:0];
               rsp_in.probability       = quo_ff;
               rsp_in.last_probability  = is_last;
               rsp_in.overflow          = job.dropped;
               idx_in                   = idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smx_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      t_ff    <= t_in;
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

// ----- sv/softmax_vector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// softmax_vector_unit
// Streaming softmax over one vector of signed Q8.8 scores.
// ----------------------------------------------------------------------------
// Input channel req_*: one score per item, last_logit closes the vector.
// Scores are taken one per cycle while a score bank is free; scores beyond
// MAX_ELEMENTS are dropped and the vector's results carry overflow.
// Result channel rsp_*: one item per stored score, in arrival order, with
// its index, probability in Q1.16 and last_probability on the final one.
// Two score banks and a two-entry job queue let the front take the next
// vector while the back still works on the previous one; the front stalls
// only when both banks hold pending vectors.
// Back work per vector: for each score, the exponential (memory read,
// scale multiply, table interpolation); then for each score, the result
// (memory read, divider load, the 17-step serial divider, output state);
// the first result follows the last exponential of the vector.
// A stalled result holds its output register and the back waits.
// Reset (synchronous) empties the queue and clears vector state; memory
// contents need no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module softmax_vector_unit #(
   parameter int MAX_ELEMENTS = smx_pkg::MAX_ELEMENTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire smx_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smx_pkg::rsp_type      rsp_item
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);

   smx_pkg::queue_status_type qstatus;
   smx_pkg::job_type          push_job;
   smx_pkg::job_type          head_job;
   logic                      push;
   logic                      pop;
   logic                      score_we;
   logic [IDX_W:0]            score_waddr;
   logic [15:0]               score_wdata;
   logic [IDX_W:0]            score_raddr;
   logic [15:0]               score_rdata;
   logic                      exp_we;
   logic [IDX_W-1:0]          exp_addr;
   logic [smx_pkg::EXP_W-1:0] exp_wdata;
   logic [smx_pkg::EXP_W-1:0] exp_rdata;

   smx_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .req_stall   (req_stall),
      .qstatus     (qstatus),
      .score_we    (score_we),
      .score_waddr (score_waddr),
      .score_wdata (score_wdata),
      .push        (push),
      .push_job    (push_job)
   );

   smx_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (qstatus)
   );

   // two banks of scores, one per queue slot
   smx_ram #(.WIDTH(16), .DEPTH(2 ** (IDX_W + 1))) u_score_ram (
      .clock   (clock),
      .wr_en   (score_we),
      .wr_addr (score_waddr),
      .wr_data (score_wdata),
      .rd_addr (score_raddr),
      .rd_data (score_rdata)
   );

   smx_ram #(.WIDTH(smx_pkg::EXP_W), .DEPTH(2 ** IDX_W)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (exp_addr),
      .wr_data (exp_wdata),
      .rd_addr (exp_addr),
      .rd_data (exp_rdata)
   );

   smx_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (head_job),
      .qstatus     (qstatus),
      .pop         (pop),
      .score_raddr (score_raddr),
      .score_rdata (score_rdata),
      .exp_we      (exp_we),
      .exp_addr    (exp_addr),
      .exp_wdata   (exp_wdata),
      .exp_rdata   (exp_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the softmax vector unit: scores are streamed in,
// expected probabilities are computed per vector and compared in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int NMAX = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   smx_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   smx_pkg::rsp_type rsp_item;

   softmax_vector_unit #(.MAX_ELEMENTS(NMAX)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state for the vector being collected
   logic signed [15:0] vec_scores[NMAX];
   int                 vec_count = 0;
   logic signed [15:0] vec_max = 16'sh8000;
   bit                 vec_dropped = 1'b0;
   smx_pkg::rsp_type   prob_queue[$];

   int  fail_count = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_rsp = 1'b0;

   localparam int unsigned POW2[17] = '{65536, 62757, 60097, 57549, 55109, 52773,
      50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

   // exp(-d) in Q0.16, d in Q8.8
   function automatic int unsigned exp_q16(int unsigned d);
      int unsigned t, k, j, r, a, b, m;
      if (d > 4096) return 0;
      t = (d * 369 + 128) >> 8;
      k = t >> 8;
      j = (t >> 4) & 15;
      r = t & 15;
      a = POW2[j];
      b = POW2[j + 1];
      m = a - (((a - b) * r + 8) >> 4);
      if (k >= 17) return 0;
      return m >> k;
   endfunction

   // absorb one accepted score, emit expectations on the last one
   task automatic predict_score(smx_pkg::req_type it);
      int unsigned e[NMAX];
      longint unsigned sum, p;
      smx_pkg::rsp_type r;
      if (vec_count < NMAX) begin
         vec_scores[vec_count] = it.logit;
         vec_count++;
         if (it.logit > vec_max) vec_max = it.logit;
      end else begin
         vec_dropped = 1'b1;
      end
      if (it.last_logit) begin
         sum = 0;
         for (int i = 0; i < vec_count; i++) begin
            e[i] = exp_q16(int'(vec_max) - int'(vec_scores[i]));
            sum += e[i];
         end
         for (int i = 0; i < vec_count; i++) begin
            p = (longint'(e[i]) * 65536 + (sum >> 1)) / sum;
            r.elem_index = i[3:0];
            r.probability = p[16:0];
            r.last_probability = (i + 1 == vec_count);
            r.overflow = vec_dropped;
            prob_queue.push_back(r);
         end
         vec_count = 0;
         vec_max = 16'sh8000;
         vec_dropped = 1'b0;
      end
   endtask

   // offer one score and wait for acceptance; valid stays up for the next one
   task automatic send_score(logic signed [15:0] logit, logic last);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item.logit <= logit;
      req_item.last_logit <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_score('{logit: logit, last_logit: last});
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (prob_queue.size() == 0) begin
            $display("%0t unexpected result: actual %p", $time, rsp_item);
            fail_count++;
         end else begin
            if (rsp_item !== prob_queue[0]) begin
               $display("%0t mismatch: expected %p actual %p", $time, prob_queue[0],
                  rsp_item);
               fail_count++;
            end
            void'(prob_queue.pop_front());
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_vector(int len, bit wide);
      logic signed [15:0] v;
      for (int i = 0; i < len; i++) begin
         if (wide) v = 16'($urandom);
         else v = 16'($urandom_range(3000, 0) - 1500);
         send_score(v, i == len - 1);
      end
   endtask

   // drop valid, then wait for all expected results
   task automatic drain();
      req_valid <= 1'b0;
      while (prob_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic test_directed();
      send_score(16'sh7fff, 1'b1);                         // single score
      send_score(16'sh8000, 1'b0); send_score(16'sh7fff, 1'b1);  // extremes
      send_score(16'sd0, 1'b0); send_score(16'sd4096, 1'b0); send_score(16'sd4097, 1'b1);
      send_score(16'sd256, 1'b0); send_score(16'sd256, 1'b1);   // ties
      for (int i = 0; i < 18; i++) send_score(16'(i * 100), i == 17);  // dropped scores
      drain();
   endtask

   task automatic test_random(int n_items, int idle, int stall);
      int sent, len;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 16) : $urandom_range(6, 1);
         send_vector(len, $urandom_range(3, 0) == 0);
         sent += len;
      end
      drain();
   endtask

   // long receiver hold so the banks fill and the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int v = 0; v < 5; v++) send_vector(4, 1'b0);
      join
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(90, 0, 0);
      test_random(80, 56, 0);
      test_random(80, 0, 56);
      test_random(80, 12, 12);
      test_backpressure();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
